// ===== rtl/tteh_pkg.sv =====
`default_nettype none

package tteh_pkg;

	localparam int KEY_W = 64;
	localparam int ENG_W = 4;
	localparam int DL_W  = 49;
	localparam int TTL_W = 40;
	localparam int NOW_W = 48;
	localparam int CMD_W = 3;
	localparam int BUD_W = 6;
	localparam int SEC_W = 31;
	localparam int ENT_W = KEY_W + ENG_W + DL_W;

	localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME  = 32'd16777619;
	localparam logic [9:0] MS_PER_S    = 10'd1000;
	localparam logic [SEC_W-1:0] TTL_SAT = '1;

	localparam logic [CMD_W-1:0] CMD_SET     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_EXPIRED = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TTL     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SWEEP   = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_EXPIRED  = 2'd2;
	localparam logic [1:0] ST_REJECT   = 2'd3;

	typedef struct packed {
		logic [1:0]       status;
		logic [SEC_W-1:0] ttl_seconds;
		logic             expired_flag;
		logic [ENG_W-1:0] removed_engine;
		logic [KEY_W-1:0] removed_key;
		logic [BUD_W-1:0] removed_count;
		logic             is_removal;
		logic             last;
	} rsp_t;

	// Bytes from the first zero byte upwards, and beyond the key length, are cleared.
	function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k, input int nbytes);
		logic [KEY_W-1:0] r;
		logic stop;
		r = '0;
		stop = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (i >= nbytes || k[8*i +: 8] == 8'd0) stop = 1'b1;
			if (!stop) r[8*i +: 8] = k[8*i +: 8];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/tteh_ifs.sv =====
`default_nettype none

interface tteh_req_if import tteh_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [ENG_W-1:0] engine;
	logic [KEY_W-1:0] key_word;
	logic [TTL_W-1:0] ttl_ms;
	logic [BUD_W-1:0] sweep_budget;
	logic [NOW_W-1:0] now_ms;

	modport source(output valid, command, engine, key_word, ttl_ms, sweep_budget, now_ms,
		input ready);
	modport sink(input valid, command, engine, key_word, ttl_ms, sweep_budget, now_ms,
		output ready);
endinterface

interface tteh_rsp_if import tteh_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [SEC_W-1:0] ttl_seconds;
	logic             expired_flag;
	logic [ENG_W-1:0] removed_engine;
	logic [KEY_W-1:0] removed_key;
	logic [BUD_W-1:0] removed_count;
	logic             is_removal;
	logic             last;

	modport source(output valid, status, ttl_seconds, expired_flag, removed_engine,
		removed_key, removed_count, is_removal, last, input ready);
	modport sink(input valid, status, ttl_seconds, expired_flag, removed_engine,
		removed_key, removed_count, is_removal, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/ttl_expiry_hash_table.sv =====
`default_nettype none

// Hashed expiry table for (engine, key) entries, one row of WAYS entries per bucket held in a
// single synchronous RAM together with the bucket's fill. After reset a clearing pass writes
// every row, during which no request is taken. Requests are handled one at a time. A set,
// delete or query takes the FNV-1a hash (over each key byte up to the first zero byte, then the
// engine), a reduction to the bucket (a mask when BUCKET_COUNT is a power of two, else a
// multiply by the reciprocal and a remainder), then a row read, a decision step and the result
// transfer. A TTL query whose entry is live adds the division by 1000. A sweep reads each
// visited bucket's row and examines its ways in turn, with one result transfer per removal.
module ttl_expiry_hash_table import tteh_pkg::*; #(
	parameter int BUCKET_COUNT = 64,
	parameter int WAYS = 4,
	parameter int KEY_BYTES = 8
) (
	input wire logic   clk,
	input wire logic   arst_n,
	tteh_req_if.sink   request,
	tteh_rsp_if.source response
);
	localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
	localparam int FW = $clog2(WAYS + 1);
	localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ROW_W = FW + WAYS * ENT_W;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_HASH, S_LOAD, S_EXEC, S_DIV,
		S_SW_READ, S_SW_LOAD, S_SW_SCAN, S_EMIT
	} state_t;

	state_t           state_q;
	state_t           ret_q;
	logic [BW-1:0]    bucket_q;
	logic [CMD_W-1:0] cmd_q;
	logic [ENG_W-1:0] eng_q;
	logic [KEY_W-1:0] key_q;
	logic [TTL_W-1:0] ttl_q;
	logic [BUD_W-1:0] budget_q;
	logic [NOW_W-1:0] now_q;
	logic [BUD_W-1:0] removed_q;
	logic [FW-1:0]    way_q;
	logic [FW-1:0]    fill_q;
	logic [KEY_W-1:0] rkey_q [WAYS];
	logic [ENG_W-1:0] reng_q [WAYS];
	logic [DL_W-1:0]  rdl_q  [WAYS];
	logic             valid_q;
	rsp_t             out_q;

	logic [KEY_W-1:0] in_key;
	logic             hash_done;
	logic [BW-1:0]    hash_bucket;
	logic             div_start;
	logic             div_done;
	logic [SEC_W-1:0] div_sec;

	logic             we;
	logic [BW-1:0]    waddr;
	logic [ROW_W-1:0] wdata;
	logic [BW-1:0]    raddr;
	logic [ROW_W-1:0] rdata;

	logic [WAYS-1:0]  hit;
	logic             hit_any;
	logic [WW-1:0]    hit_way;
	logic [DL_W-1:0]  hit_dl;
	logic [DL_W-1:0]  now49;
	logic [DL_W-1:0]  dl_new;
	logic             hit_exp;
	logic [WW-1:0]    sw_way;
	logic             sw_exp;
	logic             sw_more;
	logic [WW-1:0]    rm_idx;
	logic [KEY_W-1:0] rm_key [WAYS];
	logic [ENG_W-1:0] rm_eng [WAYS];
	logic [DL_W-1:0]  rm_dl  [WAYS];
	logic [KEY_W-1:0] w_key  [WAYS];
	logic [ENG_W-1:0] w_eng  [WAYS];
	logic [DL_W-1:0]  w_dl   [WAYS];
	logic [FW-1:0]    w_fill;

	assign in_key = norm_key(request.key_word, KEY_BYTES);

	tteh_hash #(.BUCKET_COUNT(BUCKET_COUNT)) u_hash (
		.clk(clk), .arst_n(arst_n),
		.start(state_q == S_IDLE && request.valid && request.command < CMD_SWEEP),
		.key(in_key), .engine(request.engine),
		.done(hash_done), .bucket(hash_bucket)
	);

	tteh_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(hit_dl - now49), .done(div_done), .seconds(div_sec)
	);

	tteh_ram #(.WIDTH(ROW_W), .DEPTH(BUCKET_COUNT)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign raddr = (state_q == S_HASH) ? hash_bucket : bucket_q;

	always_comb begin
		now49 = {1'b0, now_q};
		dl_new = now49 + DL_W'(ttl_q);
		hit = '0;
		for (int j = 0; j < WAYS; j++) begin
			hit[j] = (FW'(j) < fill_q) && reng_q[j] == eng_q && rkey_q[j] == key_q;
		end
		hit_any = |hit;
		hit_way = '0;
		for (int j = WAYS - 1; j >= 0; j--) begin
			if (hit[j]) hit_way = WW'(j);
		end
		hit_dl = rdl_q[hit_way];
		hit_exp = now49 >= hit_dl;
		sw_way = way_q[WW-1:0];
		sw_exp = now49 >= rdl_q[sw_way];
		sw_more = way_q < fill_q && removed_q < budget_q;
		div_start = state_q == S_EXEC && cmd_q == CMD_TTL && hit_any && !hit_exp;

		// Removal closes the gap by moving the older entries one way down.
		rm_idx = (state_q == S_SW_SCAN) ? sw_way : hit_way;
		for (int j = 0; j < WAYS - 1; j++) begin
			rm_key[j] = (j >= int'(rm_idx)) ? rkey_q[j+1] : rkey_q[j];
			rm_eng[j] = (j >= int'(rm_idx)) ? reng_q[j+1] : reng_q[j];
			rm_dl[j]  = (j >= int'(rm_idx)) ? rdl_q[j+1]  : rdl_q[j];
		end
		rm_key[WAYS-1] = rkey_q[WAYS-1];
		rm_eng[WAYS-1] = reng_q[WAYS-1];
		rm_dl[WAYS-1]  = rdl_q[WAYS-1];

		for (int j = 0; j < WAYS; j++) begin
			w_key[j] = rkey_q[j];
			w_eng[j] = reng_q[j];
			w_dl[j]  = rdl_q[j];
		end
		w_fill = fill_q;
		we = 1'b0;
		waddr = bucket_q;

		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				w_fill = '0;
			end
			S_EXEC: begin
				if (cmd_q == CMD_SET && ttl_q != '0 && hit_any) begin
					we = 1'b1;
					w_dl[hit_way] = dl_new;
				end else if (cmd_q == CMD_SET && ttl_q != '0 && fill_q < FW'(WAYS)) begin
					// A new entry goes in front; the others age by one way.
					we = 1'b1;
					for (int j = 1; j < WAYS; j++) begin
						w_key[j] = rkey_q[j-1];
						w_eng[j] = reng_q[j-1];
						w_dl[j]  = rdl_q[j-1];
					end
					w_key[0] = key_q;
					w_eng[0] = eng_q;
					w_dl[0]  = dl_new;
					w_fill = fill_q + FW'(1);
				end else if (cmd_q == CMD_DELETE && hit_any) begin
					we = 1'b1;
					for (int j = 0; j < WAYS; j++) begin
						w_key[j] = rm_key[j];
						w_eng[j] = rm_eng[j];
						w_dl[j]  = rm_dl[j];
					end
					w_fill = fill_q - FW'(1);
				end
			end
			S_SW_SCAN: begin
				we = !sw_more;
			end
			default: begin
				we = 1'b0;
			end
		endcase

		wdata = '0;
		wdata[FW-1:0] = w_fill;
		for (int j = 0; j < WAYS; j++) begin
			wdata[FW + j*ENT_W +: ENT_W] = {w_key[j], w_eng[j], w_dl[j]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ret_q <= S_IDLE;
			bucket_q <= '0;
			valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					bucket_q <= bucket_q + BW'(1);
					if (bucket_q == BW'(BUCKET_COUNT - 1)) begin
						bucket_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (request.valid) begin
						cmd_q <= request.command;
						eng_q <= request.engine;
						key_q <= in_key;
						ttl_q <= request.ttl_ms;
						budget_q <= request.sweep_budget;
						now_q <= request.now_ms;
						out_q <= '0;
						out_q.last <= 1'b1;
						if (request.command == CMD_SWEEP) begin
							bucket_q <= '0;
							removed_q <= '0;
							state_q <= S_SW_READ;
						end else if (request.command > CMD_SWEEP) begin
							out_q.status <= ST_REJECT;
							valid_q <= 1'b1;
							ret_q <= S_IDLE;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: begin
					if (hash_done) begin
						bucket_q <= hash_bucket;
						state_q <= S_LOAD;
					end
				end
				S_LOAD, S_SW_LOAD: begin
					fill_q <= rdata[FW-1:0];
					for (int j = 0; j < WAYS; j++) begin
						{rkey_q[j], reng_q[j], rdl_q[j]} <= rdata[FW + j*ENT_W +: ENT_W];
					end
					way_q <= '0;
					state_q <= (state_q == S_LOAD) ? S_EXEC : S_SW_SCAN;
				end
				S_EXEC: begin
					ret_q <= S_IDLE;
					state_q <= S_EMIT;
					valid_q <= 1'b1;
					case (cmd_q)
						CMD_SET: begin
							if (ttl_q == '0 || (!hit_any && fill_q >= FW'(WAYS)))
								out_q.status <= ST_REJECT;
						end
						CMD_DELETE: begin
							if (!hit_any) out_q.status <= ST_NOTFOUND;
						end
						CMD_EXPIRED: begin
							if (!hit_any) out_q.status <= ST_NOTFOUND;
							else out_q.expired_flag <= hit_exp;
						end
						CMD_TTL: begin
							if (!hit_any) begin
								out_q.status <= ST_NOTFOUND;
							end else if (hit_exp) begin
								out_q.status <= ST_EXPIRED;
							end else begin
								valid_q <= 1'b0;
								state_q <= S_DIV;
							end
						end
						default: out_q.status <= ST_REJECT;
					endcase
				end
				S_DIV: begin
					if (div_done) begin
						out_q.ttl_seconds <= div_sec;
						valid_q <= 1'b1;
						state_q <= S_EMIT;
					end
				end
				S_SW_READ: begin
					state_q <= S_SW_LOAD;
				end
				S_SW_SCAN: begin
					if (sw_more) begin
						if (sw_exp) begin
							out_q <= '0;
							out_q.removed_engine <= reng_q[sw_way];
							out_q.removed_key <= rkey_q[sw_way];
							out_q.is_removal <= 1'b1;
							for (int j = 0; j < WAYS; j++) begin
								rkey_q[j] <= rm_key[j];
								reng_q[j] <= rm_eng[j];
								rdl_q[j] <= rm_dl[j];
							end
							fill_q <= fill_q - FW'(1);
							removed_q <= removed_q + BUD_W'(1);
							valid_q <= 1'b1;
							ret_q <= S_SW_SCAN;
							state_q <= S_EMIT;
						end else begin
							way_q <= way_q + FW'(1);
						end
					end else if (bucket_q == BW'(BUCKET_COUNT - 1) || removed_q >= budget_q) begin
						out_q <= '0;
						out_q.removed_count <= removed_q;
						out_q.last <= 1'b1;
						valid_q <= 1'b1;
						ret_q <= S_IDLE;
						state_q <= S_EMIT;
					end else begin
						bucket_q <= bucket_q + BW'(1);
						state_q <= S_SW_READ;
					end
				end
				S_EMIT: begin
					if (response.ready) begin
						valid_q <= 1'b0;
						state_q <= ret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign request.ready = state_q == S_IDLE;
	assign response.valid = valid_q;
	assign response.status = out_q.status;
	assign response.ttl_seconds = out_q.ttl_seconds;
	assign response.expired_flag = out_q.expired_flag;
	assign response.removed_engine = out_q.removed_engine;
	assign response.removed_key = out_q.removed_key;
	assign response.removed_count = out_q.removed_count;
	assign response.is_removal = out_q.is_removal;
	assign response.last = out_q.last;
endmodule

`default_nettype wire

// ===== rtl/tteh_ram.sv =====
`default_nettype none

module tteh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                  clk,
	input  wire logic                  we,
	input  wire logic [AW-1:0]         waddr,
	input  wire logic [WIDTH-1:0]      wdata,
	input  wire logic [AW-1:0]         raddr,
	output logic      [WIDTH-1:0]      rdata
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

`default_nettype wire

// ===== rtl/tteh_hash.sv =====
`default_nettype none

module tteh_hash import tteh_pkg::*; #(
	parameter int BUCKET_COUNT = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [KEY_W-1:0] key,
	input  wire logic [ENG_W-1:0] engine,
	output logic                  done,
	output logic [BW-1:0]         bucket
);
	localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
	localparam bit POW2 = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;
	localparam logic [BW-1:0] MASK = BW'(BUCKET_COUNT - 1);
	// Reciprocal of the bucket count scaled by 2^(32+BW) and rounded up, which gives the exact
	// quotient for any 32-bit hash.
	localparam int SH = 32 + BW;
	localparam logic [32:0] RECIP =
		33'(((64'd1 << SH) + 64'(BUCKET_COUNT) - 64'd1) / 64'(BUCKET_COUNT));

	typedef enum logic [1:0] {H_IDLE, H_BYTE, H_MOD, H_RED} hstate_t;

	hstate_t          state_q;
	logic [31:0]      h_q;
	logic [KEY_W-1:0] key_q;
	logic [ENG_W-1:0] eng_q;
	logic [3:0]       idx_q;
	logic [31:0]      quot_q;

	logic [7:0]  cur_byte;
	logic        use_byte;
	logic [31:0] mix;
	logic [31:0] prod;
	logic [64:0] qprod;
	logic [31:0] rem;

	always_comb begin
		cur_byte = key_q[8*idx_q[2:0] +: 8];
		use_byte = !idx_q[3] && cur_byte != 8'd0;
		mix = use_byte ? {24'd0, cur_byte} : {28'd0, eng_q};
		prod = (h_q ^ mix) * FNV_PRIME;
		qprod = {33'd0, h_q} * {32'd0, RECIP};
		rem = h_q - quot_q * 32'(BUCKET_COUNT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				H_IDLE: begin
					if (start) begin
						h_q <= FNV_OFFSET;
						key_q <= key;
						eng_q <= engine;
						idx_q <= '0;
						state_q <= H_BYTE;
					end
				end
				H_BYTE: begin
					h_q <= prod;
					if (use_byte) begin
						idx_q <= idx_q + 4'd1;
					end else begin
						state_q <= H_MOD;
					end
				end
				H_MOD: begin
					if (POW2) begin
						bucket <= h_q[BW-1:0] & MASK;
						done <= 1'b1;
						state_q <= H_IDLE;
					end else begin
						quot_q <= 32'(qprod >> SH);
						state_q <= H_RED;
					end
				end
				H_RED: begin
					bucket <= rem[BW-1:0];
					done <= 1'b1;
					state_q <= H_IDLE;
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end
endmodule

`default_nettype wire

// ===== rtl/tteh_div.sv =====
`default_nettype none

module tteh_div import tteh_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [DL_W-1:0] dividend,
	output logic                 done,
	output logic [SEC_W-1:0]     seconds
);
	// The quotient by 1000 is the quotient of (d >> 3) by 125, taken as a multiply by 2^45 / 125
	// rounded up. That is exact for the 38 bits left whenever the result does not saturate.
	// The product is built from four partial products, one a cycle.
	localparam logic [38:0] RECIP = 39'd281474976711;
	localparam logic [DL_W-1:0] SAT_MS = DL_W'(MS_PER_S) * DL_W'(TTL_SAT);

	typedef enum logic [1:0] {D_IDLE, D_MUL, D_REM, D_FIN} dstate_t;

	dstate_t          state_q;
	logic [DL_W-1:0]  d_q;
	logic [1:0]       step_q;
	logic [79:0]      acc_q;
	logic [SEC_W-1:0] q_q;

	logic [37:0]     x;
	logic [18:0]     xpart;
	logic [19:0]     mpart;
	logic [38:0]     pp;
	logic [79:0]     term;
	logic [DL_W-1:0] qk;
	logic            sat;

	always_comb begin
		x = d_q[40:3];
		xpart = step_q[0] ? x[37:19] : x[18:0];
		mpart = step_q[1] ? {1'b0, RECIP[38:20]} : RECIP[19:0];
		pp = {20'd0, xpart} * {19'd0, mpart};
		case (step_q)
			2'd0: term = {41'd0, pp};
			2'd1: term = {22'd0, pp, 19'd0};
			2'd2: term = {21'd0, pp, 20'd0};
			default: term = {2'd0, pp, 39'd0};
		endcase
		qk = (DL_W'(q_q) << 10) - (DL_W'(q_q) << 5) + (DL_W'(q_q) << 3);
		sat = d_q > SAT_MS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (start) begin
						d_q <= dividend;
						acc_q <= '0;
						step_q <= '0;
						state_q <= D_MUL;
					end
				end
				D_MUL: begin
					acc_q <= acc_q + term;
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) state_q <= D_REM;
				end
				D_REM: begin
					q_q <= acc_q[75:45];
					state_q <= D_FIN;
				end
				D_FIN: begin
					// Round up on any remainder, then saturate.
					seconds <= sat ? TTL_SAT : q_q + SEC_W'(d_q != qk);
					done <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end
endmodule

`default_nettype wire

// ===== rtl/tteh_chk.sv =====
`default_nettype none

module tteh_chk import tteh_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_ready,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic [1:0] rsp_status,
	input wire logic       rsp_is_removal,
	input wire logic       rsp_last
);
	// Requests are taken only while no result is pending.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid)) else $error("request taken while a result waits");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready) else $error("ready held after a transfer");

	a_tail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> rsp_is_removal) else $error("non-final result not a removal");

	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_is_removal |-> rsp_status == ST_OK && !rsp_last)
		else $error("malformed removal result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_last) && $stable(rsp_status))
		else $error("stalled result changed");
endmodule

bind ttl_expiry_hash_table tteh_chk u_tteh_chk (
	.clk(clk), .arst_n(arst_n),
	.req_valid(request.valid), .req_ready(request.ready),
	.rsp_valid(response.valid), .rsp_ready(response.ready),
	.rsp_status(response.status), .rsp_is_removal(response.is_removal),
	.rsp_last(response.last)
);

`default_nettype wire
